// ===== design/gfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfps_pkg;

   // fixed-point format of shading quantities
   localparam int FRAC_BITS = 15;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int ONE_INT   = 1 << FRAC_BITS;

   localparam logic [FX_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FX_W-1:0] HALF_FX = {2'b01, {(FRAC_BITS - 1){1'b0}}};

   // sky reflection color, rounded to nearest
   localparam logic [FX_W-1:0] SKY_R_FX = FX_W'((ONE_INT * 4 + 2) / 5);
   localparam logic [FX_W-1:0] SKY_G_FX = FX_W'((ONE_INT * 17 + 10) / 20);
   localparam logic [FX_W-1:0] SKY_B_FX = FX_W'((ONE_INT * 9 + 5) / 10);

   // ior is Q2.14
   localparam logic [15:0] IOR_ONE = 16'd16384;

   // dot product is signed Q6.28, clamp point is 1.0
   localparam int DOT_W = 34;
   localparam logic signed [DOT_W-1:0] DOT_ONE = 34'sd268435456;

   // channel datapath widths
   localparam int BT_W  = 33 - FRAC_BITS;
   localparam int ED_W  = FX_W + 17;
   localparam int RF_W  = BT_W + FX_W + 1;
   localparam int MX_W  = (BT_W > FX_W) ? BT_W : FX_W;
   localparam int COL_W = ((MX_W > 16) ? MX_W : 16) + 2;
   localparam int PA_W  = COL_W + FX_W;
   localparam int PB_W  = 16 + FX_W;
   localparam int BL_W  = COL_W + FX_W + 1;
   localparam int OPW   = (FX_W > 16) ? FX_W : 16;

   // r0 divider widths
   localparam int QB    = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(QB);
   localparam int DEN_W = 34;
   localparam int REM_W = DEN_W + QB + 1;

   // pipeline depth from transfer in to result strobe
   localparam int PIPE_DEPTH = 10;

   // register file
   localparam int CSR_AW = 5;
   localparam logic [2:0] CSR_IOR     = 3'd0;
   localparam logic [2:0] CSR_TINT_R  = 3'd1;
   localparam logic [2:0] CSR_TINT_G  = 3'd2;
   localparam logic [2:0] CSR_TINT_B  = 3'd3;
   localparam logic [2:0] CSR_OPACITY = 3'd4;

   localparam logic [15:0] IOR_RESET  = 16'd24576;
   localparam logic [15:0] TINT_RESET = 16'd32768;
   localparam logic [15:0] OPAC_RESET = 16'd32768;

   typedef struct packed {
      logic [15:0]           ior;
      logic [2:0][15:0]      tint;
      logic [FX_W-1:0]       alpha;
   } cfg_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_SQUARE,
      DIV_LOAD,
      DIV_RUN
   } div_state_type;

   // product of two fractions, rounded half up
   function automatic logic [FX_W-1:0] mulr_fx(input logic [FX_W-1:0] a,
                                                input logic [FX_W-1:0] b);
      logic [2*FX_W-1:0] p;
      p = (2*FX_W)'(a) * (2*FX_W)'(b) + (2*FX_W)'(HALF_FX);
      return p[FRAC_BITS +: FX_W];
   endfunction

endpackage

`default_nettype wire

// ===== design/gfps_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfps_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [gfps_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready,
   output gfps_pkg::cfg_type                 cfg,
   output logic                              ior_wr
);
   import gfps_pkg::*;

   logic [15:0]      ior_ff;
   logic [2:0][15:0] tint_ff;
   logic [15:0]      opac_ff;
   logic             wr_en;
   logic [2:0]       idx;
   logic [OPW-1:0]   opac_w;
   logic [15:0]      rd_val;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[CSR_AW-1:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ior_ff  <= IOR_RESET;
         tint_ff <= {TINT_RESET, TINT_RESET, TINT_RESET};
         opac_ff <= OPAC_RESET;
      end else if (wr_en) begin
         unique case (idx)
            CSR_IOR:     ior_ff     <= pwdata[15:0];
            CSR_TINT_R:  tint_ff[0] <= pwdata[15:0];
            CSR_TINT_G:  tint_ff[1] <= pwdata[15:0];
            CSR_TINT_B:  tint_ff[2] <= pwdata[15:0];
            CSR_OPACITY: opac_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // readback
   always_comb begin
      unique case (idx)
         CSR_IOR:     rd_val = ior_ff;
         CSR_TINT_R:  rd_val = tint_ff[0];
         CSR_TINT_G:  rd_val = tint_ff[1];
         CSR_TINT_B:  rd_val = tint_ff[2];
         CSR_OPACITY: rd_val = opac_ff;
         default:     rd_val = 16'h0000;
      endcase
   end
   assign prdata = {16'h0000, rd_val};

   // alpha clamps at one
   assign opac_w = OPW'(opac_ff);
   always_comb begin
      cfg.ior  = ior_ff;
      cfg.tint = tint_ff;
      if (opac_w > OPW'(ONE_FX)) begin
         cfg.alpha = ONE_FX;
      end else begin
         cfg.alpha = opac_w[FX_W-1:0];
      end
   end

   assign ior_wr = wr_en && (idx == CSR_IOR);

endmodule

`default_nettype wire

// ===== design/gfps_r0_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfps_r0_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [15:0]                 ior,
   input  wire logic                        ior_wr,
   output logic                             busy,
   output logic      [gfps_pkg::FX_W-1:0]   r0
);
   import gfps_pkg::*;

   div_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [31:0]       dsq_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  dvs_ff;
   logic [QB-1:0]     q_ff;
   logic [FX_W-1:0]   r0_ff;
   logic [15:0]       diff;
   logic [16:0]       ior_sum;
   logic              ge;
   logic [QB-1:0]     q_next;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_SQUARE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == DIV_LOAD) begin
            cnt_ff <= CNT_W'(QB - 1);
         end else if (state_ff == DIV_RUN) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // next state, busy flag
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE:   state_in = DIV_IDLE;
         DIV_SQUARE: state_in = DIV_LOAD;
         DIV_LOAD:   state_in = DIV_RUN;
         DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = DIV_IDLE;
            end
         end
         default:    state_in = DIV_IDLE;
      endcase
      // new ior restarts the divide
      if (ior_wr) begin
         state_in = DIV_SQUARE;
      end
      busy = (state_ff != DIV_IDLE);
   end

   // |1 - ior| and 1 + ior
   assign diff    = (ior >= IOR_ONE) ? (ior - IOR_ONE) : (IOR_ONE - ior);
   assign ior_sum = 17'(ior) + 17'(IOR_ONE);

   // restoring divide, one quotient bit a cycle
   assign ge     = (rem_ff >= dvs_ff);
   assign q_next = {q_ff[QB-2:0], ge};

   always_ff @(posedge clock) begin
      unique case (state_ff)
         DIV_SQUARE: begin
            dsq_ff <= 32'(diff) * 32'(diff);
            den_ff <= DEN_W'(ior_sum) * DEN_W'(ior_sum);
         end
         DIV_LOAD: begin
            rem_ff <= REM_W'({dsq_ff, {FRAC_BITS{1'b0}}}) + REM_W'(den_ff >> 1);
            dvs_ff <= REM_W'(den_ff) << (QB - 1);
            q_ff   <= '0;
         end
         DIV_RUN: begin
            if (ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            dvs_ff <= dvs_ff >> 1;
            q_ff   <= q_next;
            if (cnt_ff == '0) begin
               r0_ff <= (q_next > QB'(ONE_FX)) ? ONE_FX : FX_W'(q_next);
            end
         end
         default: ;
      endcase
   end

   assign r0 = r0_ff;

   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(state_ff == DIV_RUN && cnt_ff == '0))
      else $error("busy dropped before the divide finished");

   a_r0_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_IDLE) |-> (r0_ff <= ONE_FX))
      else $error("r0 above one while idle");

endmodule

`default_nettype wire

// ===== design/gfps_fresnel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfps_fresnel (
   input  wire logic                         clock,
   input  wire logic signed [15:0]           normal_x,
   input  wire logic signed [15:0]           normal_y,
   input  wire logic signed [15:0]           normal_z,
   input  wire logic signed [15:0]           view_x,
   input  wire logic signed [15:0]           view_y,
   input  wire logic signed [15:0]           view_z,
   input  wire logic [gfps_pkg::FX_W-1:0]    r0,
   output logic      [gfps_pkg::FX_W-1:0]    m3,
   output logic      [gfps_pkg::FX_W-1:0]    fres
);
   import gfps_pkg::*;

   logic signed [31:0]      prx_ff, pry_ff, prz_ff;
   logic signed [DOT_W-1:0] dot;
   logic [28:0]             dcl;
   logic [FX_W-1:0]         m_s2_in, m_s2_ff, m_s3_ff;
   logic [FX_W-1:0]         msq_s3_in, msq_s3_ff, msq_s4_ff;
   logic [FX_W-1:0]         m3_s4_in, m3_s4_ff;
   logic [FX_W-1:0]         m5_s5_in, m5_s5_ff;
   logic [FX_W-1:0]         fterm;
   logic [FX_W:0]           fsum;
   logic [FX_W-1:0]         fres_s6_in, fres_s6_ff;

   // stage 2: dot product, clamp, m = 1 - c
   always_comb begin
      dot = DOT_W'(prx_ff) + DOT_W'(pry_ff) + DOT_W'(prz_ff);
      priority if (dot[DOT_W-1]) begin
         dcl = '0;
      end else if (dot > DOT_ONE) begin
         dcl = 29'(DOT_ONE);
      end else begin
         dcl = dot[28:0];
      end
      m_s2_in = ONE_FX - dcl[28:28-FRAC_BITS];
   end

   // stages 3 to 5: powers of m
   assign msq_s3_in = mulr_fx(m_s2_ff, m_s2_ff);
   assign m3_s4_in  = mulr_fx(msq_s3_ff, m_s3_ff);
   assign m5_s5_in  = mulr_fx(m3_s4_ff, msq_s4_ff);

   // stage 6: Schlick term
   always_comb begin
      fterm = mulr_fx(ONE_FX - r0, m5_s5_ff);
      fsum  = {1'b0, r0} + {1'b0, fterm};
      if (fsum > {1'b0, ONE_FX}) begin
         fres_s6_in = ONE_FX;
      end else begin
         fres_s6_in = fsum[FX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prx_ff     <= normal_x * view_x;
      pry_ff     <= normal_y * view_y;
      prz_ff     <= normal_z * view_z;
      m_s2_ff    <= m_s2_in;
      m_s3_ff    <= m_s2_ff;
      msq_s3_ff  <= msq_s3_in;
      msq_s4_ff  <= msq_s3_ff;
      m3_s4_ff   <= m3_s4_in;
      m5_s5_ff   <= m5_s5_in;
      fres_s6_ff <= fres_s6_in;
   end

   assign m3   = m3_s4_ff;
   assign fres = fres_s6_ff;

endmodule

`default_nettype wire

// ===== design/gfps_channel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfps_channel (
   input  wire logic                        clock,
   input  wire logic [15:0]                 back,
   input  wire logic [15:0]                 tint,
   input  wire logic [gfps_pkg::FX_W-1:0]   sky,
   input  wire logic [gfps_pkg::FX_W-1:0]   m3,
   input  wire logic [gfps_pkg::FX_W-1:0]   fres,
   input  wire logic [gfps_pkg::FX_W-1:0]   alpha,
   output logic      [15:0]                 shade
);
   import gfps_pkg::*;

   // backdrop delay line, tap k-1 holds stage k
   logic [7:0][15:0]   back_ff;
   logic [32:0]        bt_full;
   logic [BT_W-1:0]    bt_s3_ff, bt_s4_ff, bt_s5_ff, bt_s6_ff;
   logic [ED_W-1:0]    ed_full;
   logic [15:0]        edge_s5_ff, edge_s6_ff, edge_s7_ff;
   logic [RF_W-1:0]    rf_full;
   logic [BT_W-1:0]    refr_s7_ff;
   logic [FX_W-1:0]    refl_s7_ff;
   logic [COL_W-1:0]   col_s8_ff;
   logic [PA_W-1:0]    pa_s9_ff;
   logic [PB_W-1:0]    pb_s9_ff;
   logic [BL_W-1:0]    bl_sum;
   logic [BL_W-FRAC_BITS-1:0] bl_sh;
   logic [15:0]        shade_s10_in, shade_s10_ff;

   // backdrop times tint, and the edge glow
   assign bt_full = 33'(back_ff[1]) * 33'(tint) + 33'(HALF_FX);
   assign ed_full = ED_W'(tint) * ED_W'(m3) + ED_W'(ONE_FX);
   // refracted part
   assign rf_full = RF_W'(bt_s6_ff) * RF_W'(ONE_FX - fres) + RF_W'(HALF_FX);

   // blend and saturate
   always_comb begin
      bl_sum = BL_W'(pa_s9_ff) + BL_W'(pb_s9_ff) + BL_W'(HALF_FX);
      bl_sh  = bl_sum[BL_W-1:FRAC_BITS];
      if (|bl_sh[BL_W-FRAC_BITS-1:16]) begin
         shade_s10_in = 16'hFFFF;
      end else begin
         shade_s10_in = bl_sh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      back_ff      <= {back_ff[6:0], back};
      bt_s3_ff     <= bt_full[FRAC_BITS +: BT_W];
      bt_s4_ff     <= bt_s3_ff;
      bt_s5_ff     <= bt_s4_ff;
      bt_s6_ff     <= bt_s5_ff;
      edge_s5_ff   <= ed_full[FX_W +: 16];
      edge_s6_ff   <= edge_s5_ff;
      edge_s7_ff   <= edge_s6_ff;
      refr_s7_ff   <= rf_full[FRAC_BITS +: BT_W];
      refl_s7_ff   <= mulr_fx(sky, fres);
      col_s8_ff    <= COL_W'(refr_s7_ff) + COL_W'(refl_s7_ff) + COL_W'(edge_s7_ff);
      pa_s9_ff     <= PA_W'(col_s8_ff) * PA_W'(alpha);
      pb_s9_ff     <= PB_W'(back_ff[7]) * PB_W'(ONE_FX - alpha);
      shade_s10_ff <= shade_s10_in;
   end

   assign shade = shade_s10_ff;

endmodule

`default_nettype wire

// ===== design/glass_fresnel_pixel_shade_top.sv =====
// A result strobes on rsp_valid once its start transfer has passed through the valid chain.
// Throughput: one pixel per clock while busy is low, through a 10-stage pipeline; the receiver cannot stall.
// busy is high while the r0 divider runs its square, load and run states: after reset and after each ior write.
// Reset (synchronous) clears the pipeline valids and loads the register reset values.
// Results depend on tint, opacity and ior as they stand while the pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module glass_fresnel_pixel_shade_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [15:0]           req_normal_x,
   input  wire logic signed [15:0]           req_normal_y,
   input  wire logic signed [15:0]           req_normal_z,
   input  wire logic signed [15:0]           req_view_x,
   input  wire logic signed [15:0]           req_view_y,
   input  wire logic signed [15:0]           req_view_z,
   input  wire logic [15:0]                  req_back_red,
   input  wire logic [15:0]                  req_back_green,
   input  wire logic [15:0]                  req_back_blue,
   output logic                              rsp_valid,
   output logic      [15:0]                  rsp_out_red,
   output logic      [15:0]                  rsp_out_green,
   output logic      [15:0]                  rsp_out_blue,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [gfps_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready
);
   import gfps_pkg::*;

   cfg_type               cfg;
   logic                  ior_wr;
   logic [FX_W-1:0]       r0;
   logic [FX_W-1:0]       m3;
   logic [FX_W-1:0]       fres;
   logic                  accept;
   logic [PIPE_DEPTH-1:0] vld_ff;

   gfps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .ior_wr  (ior_wr)
   );

   gfps_r0_div u_r0_div (
      .clock  (clock),
      .reset  (reset),
      .ior    (cfg.ior),
      .ior_wr (ior_wr),
      .busy   (busy),
      .r0     (r0)
   );

   gfps_fresnel u_fresnel (
      .clock    (clock),
      .normal_x (req_normal_x),
      .normal_y (req_normal_y),
      .normal_z (req_normal_z),
      .view_x   (req_view_x),
      .view_y   (req_view_y),
      .view_z   (req_view_z),
      .r0       (r0),
      .m3       (m3),
      .fres     (fres)
   );

   gfps_channel u_chan_red (
      .clock (clock),
      .back  (req_back_red),
      .tint  (cfg.tint[0]),
      .sky   (SKY_R_FX),
      .m3    (m3),
      .fres  (fres),
      .alpha (cfg.alpha),
      .shade (rsp_out_red)
   );

   gfps_channel u_chan_green (
      .clock (clock),
      .back  (req_back_green),
      .tint  (cfg.tint[1]),
      .sky   (SKY_G_FX),
      .m3    (m3),
      .fres  (fres),
      .alpha (cfg.alpha),
      .shade (rsp_out_green)
   );

   gfps_channel u_chan_blue (
      .clock (clock),
      .back  (req_back_blue),
      .tint  (cfg.tint[2]),
      .sky   (SKY_B_FX),
      .m3    (m3),
      .fres  (fres),
      .alpha (cfg.alpha),
      .shade (rsp_out_blue)
   );

   // input transfer and valid chain
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted pixel produced no result");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result without a matching transfer");

endmodule

`default_nettype wire

// ===== dv/tb_glass_fresnel_pixel_shade_top.sv =====
`timescale 1ns / 1ps

module tb_glass_fresnel_pixel_shade_top;
   import gfps_pkg::CSR_AW;
   import gfps_pkg::CSR_IOR;
   import gfps_pkg::CSR_TINT_R;
   import gfps_pkg::CSR_TINT_G;
   import gfps_pkg::CSR_TINT_B;
   import gfps_pkg::CSR_OPACITY;
   import gfps_pkg::PIPE_DEPTH;

   // fixed-point constants of the shading math
   localparam int              FRAC      = 15;
   localparam longint unsigned UNITY     = 64'd1 << FRAC;
   localparam longint unsigned HALF      = UNITY >> 1;
   localparam longint unsigned IOR_UNITY = 64'd16384;
   localparam longint          DOT_UNITY = 64'sd1 << 28;
   localparam longint unsigned SKY_RED   = (UNITY * 4 + 2) / 5;
   localparam longint unsigned SKY_GREEN = (UNITY * 17 + 10) / 20;
   localparam longint unsigned SKY_BLUE  = (UNITY * 9 + 5) / 10;

   // register map
   localparam int         NUM_GLASS_REGS = 5;
   localparam logic [2:0] CSR_SPARE_LO   = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI   = 3'd7;
   localparam logic [2:0] GLASS_REGS [NUM_GLASS_REGS] =
      '{CSR_IOR, CSR_TINT_R, CSR_TINT_G, CSR_TINT_B, CSR_OPACITY};

   // run shape
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_LIMIT     = 10 * PIPE_DEPTH + 200;
   localparam int RAND_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int QUIET_PHASE     = 2;

   // named glass settings used by the directed rows
   localparam int SET_RESET = 0;
   localparam int SET_CLEAR = 1;
   localparam int SET_BLACK = 2;
   localparam int SET_HOT   = 3;
   localparam int SET_DENSE = 4;
   localparam int SET_WIDE  = 5;
   localparam int NUM_SETS  = 6;

   typedef logic [NUM_GLASS_REGS-1:0][15:0] glass_setting_type;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic        [15:0] br;
      logic        [15:0] bg;
      logic        [15:0] bb;
   } pixel_type;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } color_type;

   typedef struct packed {
      int        setting;
      pixel_type px;
      bit        typed;
      color_type want;
   } shade_row_type;

   localparam int N_DIR = 20;

   // directed rows; typed expectations only where obvious
   shade_row_type dir_rows [N_DIR] = '{
      // reset setting: face-on, grazing, back-facing, dot above one, 45 deg
      '{SET_RESET, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd16384, 16'd8192, 16'd32768}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_RESET, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
         16'd0, 16'd32768, 16'd12345}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_RESET, '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd32768, 16'd32768, 16'd32768}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_RESET, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
         16'sd16384, 16'd100, 16'd200, 16'd300}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_RESET, '{16'sd0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384,
         16'd20000, 16'd20000, 16'd20000}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      // raw 16-bit extremes of the vector fields
      '{SET_RESET, '{16'sh8000, 16'sd32767, -16'sd1, 16'sh8000, 16'sh8000, 16'sd0,
         16'd65535, 16'd0, 16'd32767}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_RESET, '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
         -16'sd16384, 16'd0, 16'd0, 16'd0}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      // zero opacity: backdrop passes straight through
      '{SET_CLEAR, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd12345, 16'd0, 16'd32768}, 1'b1, '{16'd12345, 16'd0, 16'd32768}},
      '{SET_CLEAR, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
         16'd65535, 16'd32767, 16'd1}, 1'b1, '{16'd65535, 16'd32767, 16'd1}},
      // r0 zero, no tint: face-on is black, grazing is pure sky
      '{SET_BLACK, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd32768, 16'd32768, 16'd32768}, 1'b1, '{16'd0, 16'd0, 16'd0}},
      '{SET_BLACK, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
         16'd1000, 16'd2000, 16'd3000}, 1'b1, '{16'd26214, 16'd27853, 16'd29491}},
      '{SET_BLACK, '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
         16'd32768, 16'd0, 16'd5}, 1'b1, '{16'd26214, 16'd27853, 16'd29491}},
      // full tint over bright backdrop saturates, dark backdrop stays black
      '{SET_HOT, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd65535, 16'd65535, 16'd65535}, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
      '{SET_HOT, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 16'd0}},
      '{SET_HOT, '{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
         16'd32768, 16'd16384, 16'd0}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      // ior zero, opacity above one
      '{SET_DENSE, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
         16'd10000, 16'd20000, 16'd30000}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_DENSE, '{16'sd3000, 16'sd5000, 16'sd15000, 16'sd2000, -16'sd4000,
         16'sd16000, 16'd40000, 16'd50000, 16'd65535}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_DENSE, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
         16'd32768, 16'd32768, 16'd32768}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      // largest ior, mixed tints
      '{SET_WIDE, '{-16'sd9000, 16'sd4000, 16'sd12000, -16'sd8000, 16'sd2000,
         16'sd14000, 16'd5000, 16'd25000, 16'd32768}, 1'b0, '{16'd0, 16'd0, 16'd0}},
      '{SET_WIDE, '{16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
         16'd65535, 16'd65535, 16'd65535}, 1'b0, '{16'd0, 16'd0, 16'd0}}
   };

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic signed [15:0]       req_normal_x   = '0;
   logic signed [15:0]       req_normal_y   = '0;
   logic signed [15:0]       req_normal_z   = '0;
   logic signed [15:0]       req_view_x     = '0;
   logic signed [15:0]       req_view_y     = '0;
   logic signed [15:0]       req_view_z     = '0;
   logic        [15:0]       req_back_red   = '0;
   logic        [15:0]       req_back_green = '0;
   logic        [15:0]       req_back_blue  = '0;
   logic                     psel           = 1'b0;
   logic                     penable        = 1'b0;
   logic                     pwrite         = 1'b0;
   logic        [CSR_AW-1:0] paddr          = '0;
   logic        [31:0]       pwdata         = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic        [15:0]       rsp_out_red;
   logic        [15:0]       rsp_out_green;
   logic        [15:0]       rsp_out_blue;
   logic        [31:0]       prdata;
   logic                     pready;

   glass_setting_type glass_now;
   glass_setting_type settings_tbl [NUM_SETS];
   color_type         pending_colors [$];
   int                mismatch_count   = 0;
   int                results_checked  = 0;
   int                pixels_sent      = 0;
   int                settings_applied = 0;
   int                regs_read        = 0;
   int                cycle_count      = 0;

   glass_fresnel_pixel_shade_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_normal_x   (req_normal_x),
      .req_normal_y   (req_normal_y),
      .req_normal_z   (req_normal_z),
      .req_view_x     (req_view_x),
      .req_view_y     (req_view_y),
      .req_view_z     (req_view_z),
      .req_back_red   (req_back_red),
      .req_back_green (req_back_green),
      .req_back_blue  (req_back_blue),
      .rsp_valid      (rsp_valid),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_colors.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // ---------------- shading predictor ----------------

   function automatic longint unsigned round_mul(input longint unsigned a,
                                                 input longint unsigned b);
      return (a * b + HALF) >> FRAC;
   endfunction

   function automatic logic [15:0] shade_one(input longint unsigned back,
                                             input longint unsigned tint,
                                             input longint unsigned sky,
                                             input longint unsigned fres,
                                             input longint unsigned m3,
                                             input longint unsigned alpha);
      longint unsigned refr, refl, rim, col, mix;
      refr = round_mul(round_mul(back, tint), UNITY - fres);
      refl = round_mul(sky, fres);
      rim  = (tint * m3 + UNITY) >> (FRAC + 1);
      col  = refr + refl + rim;
      mix  = (col * alpha + back * (UNITY - alpha) + HALF) >> FRAC;
      return (mix > 64'hFFFF) ? 16'hFFFF : mix[15:0];
   endfunction

   function automatic color_type fresnel_shade(input pixel_type px);
      longint          dot;
      longint unsigned c, m, m2, m3, m5, ior, diff, num, den, r0, fres, alpha;
      color_type       res;
      dot = longint'(px.nx) * longint'(px.vx) + longint'(px.ny) * longint'(px.vy)
          + longint'(px.nz) * longint'(px.vz);
      // back-facing is grazing, beyond one is face-on
      if (dot < 0) dot = 0;
      if (dot > DOT_UNITY) dot = DOT_UNITY;
      c = longint'(dot) >>> (28 - FRAC);
      // normal-incidence reflectance from the index of refraction
      ior  = glass_now[CSR_IOR];
      diff = (ior >= IOR_UNITY) ? ior - IOR_UNITY : IOR_UNITY - ior;
      num  = (diff * diff) << FRAC;
      den  = (ior + IOR_UNITY) * (ior + IOR_UNITY);
      r0   = (num + den / 2) / den;
      if (r0 > UNITY) r0 = UNITY;
      m  = UNITY - c;
      m2 = round_mul(m, m);
      m3 = round_mul(m2, m);
      m5 = round_mul(m3, m2);
      fres = r0 + round_mul(UNITY - r0, m5);
      if (fres > UNITY) fres = UNITY;
      alpha = (glass_now[CSR_OPACITY] > UNITY) ? UNITY : glass_now[CSR_OPACITY];
      res.r = shade_one(px.br, glass_now[CSR_TINT_R], SKY_RED, fres, m3, alpha);
      res.g = shade_one(px.bg, glass_now[CSR_TINT_G], SKY_GREEN, fres, m3, alpha);
      res.b = shade_one(px.bb, glass_now[CSR_TINT_B], SKY_BLUE, fres, m3, alpha);
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic glass_setting_type make_setting(input logic [15:0] ior,
                                                      input logic [15:0] tr,
                                                      input logic [15:0] tg,
                                                      input logic [15:0] tb,
                                                      input logic [15:0] opac);
      glass_setting_type s;
      s[CSR_IOR]     = ior;
      s[CSR_TINT_R]  = tr;
      s[CSR_TINT_G]  = tg;
      s[CSR_TINT_B]  = tb;
      s[CSR_OPACITY] = opac;
      return s;
   endfunction

   // register value biased to the extremes
   function automatic logic [15:0] pick_reg(input logic [15:0] top);
      case ($urandom_range(9))
         0: return 16'd0;
         1: return top;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(top));
      endcase
   endfunction

   function automatic logic [15:0] pick_color();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 16'($urandom());
      if (roll < 10) return 16'd0;
      if (roll < 15) return 16'd32768;
      return 16'($urandom_range(32768));
   endfunction

   function automatic logic signed [15:0] pick_component(input int amp, input bit raw);
      if (raw) return 16'($urandom());
      return 16'(int'($urandom_range(2 * amp)) - amp);
   endfunction

   function automatic int pick_amp();
      case ($urandom_range(3))
         0: return 16384;
         1: return 11585;
         2: return 8192;
         default: return 2048;
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        shape;
      int        amp;
      bit        raw;
      shape = $urandom_range(99);
      raw   = (shape >= 95);
      amp   = pick_amp();
      px.nx = pick_component(amp, raw);
      px.ny = pick_component(amp, raw);
      px.nz = pick_component(amp, raw);
      if (shape < 25) begin
         // view along the normal: front-facing, often near face-on
         px.vx = px.nx;
         px.vy = px.ny;
         px.vz = px.nz;
      end else begin
         amp   = pick_amp();
         px.vx = pick_component(amp, raw);
         px.vy = pick_component(amp, raw);
         px.vz = pick_component(amp, raw);
      end
      px.br = pick_color();
      px.bg = pick_color();
      px.bb = pick_color();
      return px;
   endfunction

   // ---------------- bus tasks ----------------

   // one pixel transfer, after an optional random gap (about 19% idle overall)
   task automatic send_pixel(input pixel_type px, input bit may_idle);
      int gap;
      gap = (may_idle && $urandom_range(99) < 12) ? int'($urandom_range(1, 3)) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_normal_x   <= px.nx;
      req_normal_y   <= px.ny;
      req_normal_z   <= px.nz;
      req_view_x     <= px.vx;
      req_view_y     <= px.vy;
      req_view_z     <= px.vz;
      req_back_red   <= px.br;
      req_back_green <= px.bg;
      req_back_blue  <= px.bb;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   // setup + access; leaves psel high so transfers can run back to back
   task automatic csr_transfer(input bit wr, input logic [2:0] idx,
                               input logic [15:0] val, output logic [31:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom()), val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
   endtask

   // program a full setting with the pipeline empty, then read it back
   task automatic apply_setting(input glass_setting_type s);
      logic [31:0] rd;
      drain_pending();
      while (busy) @(posedge clock);
      for (int i = 0; i < NUM_GLASS_REGS; i++) begin
         csr_transfer(1'b1, GLASS_REGS[i], s[GLASS_REGS[i]], rd);
         glass_now[GLASS_REGS[i]] = s[GLASS_REGS[i]];
      end
      // writes past the last register must be dropped
      csr_transfer(1'b1, CSR_SPARE_LO, 16'($urandom()), rd);
      csr_transfer(1'b1, CSR_SPARE_HI, 16'($urandom()), rd);
      for (int i = 0; i < NUM_GLASS_REGS; i++) begin
         csr_transfer(1'b0, GLASS_REGS[i], 16'd0, rd);
         regs_read++;
         if (rd[15:0] !== glass_now[GLASS_REGS[i]])
            report_mismatch($sformatf("register %0d read %h, written %h",
                                      GLASS_REGS[i], rd[15:0], glass_now[GLASS_REGS[i]]));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      settings_applied++;
   endtask

   // ---------------- result checker ----------------

   always @(posedge clock) begin : rsp_check
      color_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h %h %h", rsp_out_red,
                                      rsp_out_green, rsp_out_blue));
         end else begin
            want = pending_colors.pop_front();
            results_checked++;
            if (rsp_out_red !== want.r)
               report_mismatch($sformatf("result %0d red %h, expected %h",
                                         results_checked, rsp_out_red, want.r));
            if (rsp_out_green !== want.g)
               report_mismatch($sformatf("result %0d green %h, expected %h",
                                         results_checked, rsp_out_green, want.g));
            if (rsp_out_blue !== want.b)
               report_mismatch($sformatf("result %0d blue %h, expected %h",
                                         results_checked, rsp_out_blue, want.b));
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin : main_seq
      int        cur_set;
      int        waited;
      pixel_type px;
      settings_tbl[SET_RESET] = make_setting(16'd24576, 16'd32768, 16'd32768, 16'd32768,
                                             16'd32768);
      settings_tbl[SET_CLEAR] = make_setting(16'd24576, 16'd20000, 16'd10000, 16'd5000,
                                             16'd0);
      settings_tbl[SET_BLACK] = make_setting(16'd16384, 16'd0, 16'd0, 16'd0, 16'd32768);
      settings_tbl[SET_HOT]   = make_setting(16'd16384, 16'd65535, 16'd65535, 16'd65535,
                                             16'd32768);
      settings_tbl[SET_DENSE] = make_setting(16'd0, 16'd12345, 16'd23456, 16'd32768,
                                             16'd65535);
      settings_tbl[SET_WIDE]  = make_setting(16'd65535, 16'd32768, 16'd0, 16'd65535,
                                             16'd16384);
      glass_now = settings_tbl[SET_RESET];
      cur_set   = SET_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows; the first ones run on the reset values
      for (int i = 0; i < N_DIR; i++) begin
         if (dir_rows[i].setting != cur_set) begin
            cur_set = dir_rows[i].setting;
            apply_setting(settings_tbl[cur_set]);
         end
         send_pixel(dir_rows[i].px, 1'b1);
         pending_colors.push_back(dir_rows[i].typed ? dir_rows[i].want
                                                    : fresnel_shade(dir_rows[i].px));
      end

      // random pixels under random settings; one phase sends without random gaps
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         apply_setting(make_setting(pick_reg(16'hFFFF), pick_reg(16'd32768),
                                    pick_reg(16'd32768), pick_reg(16'd32768),
                                    pick_reg(16'd32768)));
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            px = random_pixel();
            send_pixel(px, phase != QUIET_PHASE);
            pending_colors.push_back(fresnel_shade(px));
            if ($urandom_range(99) == 0) drain_pending();
         end
      end

      // let the pipeline empty, then watch for strays
      start  <= 1'b0;
      waited = 0;
      while (pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (pending_colors.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_colors.size()));

      $display("Shaded %0d pixels (%0d directed) under %0d glass settings,",
               pixels_sent, N_DIR, settings_applied + 1);
      $display("checked %0d results and %0d register reads, %0d mismatches.",
               results_checked, regs_read, mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
